@@ sv/wfc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfc_pkg
// Shared constants, register indexes and the arctangent table of the
// waypoint follow controller.
// ----------------------------------------------------------------------------
package wfc_pkg;

    localparam int MAX_WAYPOINTS_DEF = 16;
    localparam int CORDIC_STEPS_DEF  = 16;

    // register indexes on the configuration port
    localparam logic [2:0] REG_NUM_WAYPOINTS   = 3'd0;
    localparam logic [2:0] REG_HEADING_TOL     = 3'd1;
    localparam logic [2:0] REG_POSITION_TOL    = 3'd2;
    localparam logic [2:0] REG_ROTATION_SPEED  = 3'd3;
    localparam logic [2:0] REG_FORWARD_SPEED   = 3'd4;
    localparam logic [2:0] REG_TURN_GAIN       = 3'd5;
    localparam logic [2:0] REG_CLOSED_LOOP     = 3'd6;

    localparam logic [4:0]  RST_NUM_WAYPOINTS = 5'd1;
    localparam logic [17:0] RST_HEADING_TOL   = 18'd1311;
    localparam logic [30:0] RST_POSITION_TOL  = 31'd1638;

    // opcode on the input stream
    localparam logic OP_POSE  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam int ERR_W = 22;
    localparam int Z_W   = 35;
    localparam int XY_W  = 60;

    localparam logic signed [ERR_W-1:0] PI_Q16     = 22'sd205887;
    localparam logic signed [ERR_W-1:0] TWO_PI_Q16 = 22'sd411775;
    localparam logic signed [Z_W-1:0]   PI_Q30     = 35'sd3373259426;

    // atan(2^-i) in Q2.30, truncated
    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'h3243F6A8;
            5'd1:  v = 30'h1DAC6705;
            5'd2:  v = 30'h0FADBAFC;
            5'd3:  v = 30'h07F56EA6;
            5'd4:  v = 30'h03FEAB76;
            5'd5:  v = 30'h01FFD55B;
            5'd6:  v = 30'h00FFFAAA;
            5'd7:  v = 30'h007FFF55;
            5'd8:  v = 30'h003FFFEA;
            5'd9:  v = 30'h001FFFFD;
            5'd10: v = 30'h000FFFFF;
            5'd11: v = 30'h0007FFFF;
            5'd12: v = 30'h0003FFFF;
            5'd13: v = 30'h0001FFFF;
            5'd14: v = 30'h0000FFFF;
            5'd15: v = 30'h00007FFF;
            5'd16: v = 30'h00003FFF;
            5'd17: v = 30'h00001FFF;
            5'd18: v = 30'h00000FFF;
            5'd19: v = 30'h000007FF;
            5'd20: v = 30'h000003FF;
            5'd21: v = 30'h000001FF;
            5'd22: v = 30'h000000FF;
            5'd23: v = 30'h0000007F;
            5'd24: v = 30'h0000003F;
            5'd25: v = 30'h0000001F;
            5'd26: v = 30'h0000000F;
            5'd27: v = 30'h00000007;
            5'd28: v = 30'h00000003;
            5'd29: v = 30'h00000001;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

endpackage

@@ sv/wfc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module wfc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/wfc_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfc_mul
// Shared 32 x 32 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module wfc_mul (
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] p
);

    logic [63:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

@@ sv/wfc_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfc_cordic
// Iterative vectoring CORDIC: bearing atan2(dy, dx) in signed Q6.16, one
// micro-rotation per cycle.
// ----------------------------------------------------------------------------
module wfc_cordic #(
    parameter int CORDIC_STEPS = wfc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic signed [32:0]              dx,
    input  logic signed [32:0]              dy,
    output logic                            done,
    output logic signed [wfc_pkg::ERR_W-1:0] bearing
);

    localparam int IW = $clog2(CORDIC_STEPS);

    logic signed [wfc_pkg::XY_W-1:0] x_reg;
    logic signed [wfc_pkg::XY_W-1:0] y_reg;
    logic signed [wfc_pkg::Z_W-1:0]  z_reg;
    logic [IW-1:0]                    i_reg;
    logic                             busy_reg;
    logic                             done_reg;

    logic signed [56:0]               x0;
    logic signed [56:0]               y0;
    logic signed [wfc_pkg::XY_W-1:0]  xs;
    logic signed [wfc_pkg::XY_W-1:0]  ys;
    logic signed [wfc_pkg::Z_W-1:0]   at;
    logic signed [wfc_pkg::Z_W-1:0]   zr;

    assign x0 = {dx, 24'd0};
    assign y0 = {dy, 24'd0};
    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;
    assign at = $signed({5'd0, wfc_pkg::atan_q30(5'(i_reg))});
    assign zr = z_reg + 35'sd8192;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                i_reg <= '0;
                if (dx == 33'sd0 && dy == 33'sd0)
                begin
                    z_reg    <= '0;
                    done_reg <= 1'b1;
                end
                else if (x0 < 0)
                begin
                    // left half plane: pre-rotate by pi
                    x_reg    <= -wfc_pkg::XY_W'(x0);
                    y_reg    <= -wfc_pkg::XY_W'(y0);
                    z_reg    <= (y0 >= 0) ? wfc_pkg::PI_Q30 : -wfc_pkg::PI_Q30;
                    busy_reg <= 1'b1;
                end
                else
                begin
                    x_reg    <= wfc_pkg::XY_W'(x0);
                    y_reg    <= wfc_pkg::XY_W'(y0);
                    z_reg    <= '0;
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                if (y_reg > 0)
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + at;
                end
                else
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - at;
                end
                i_reg <= i_reg + 1'b1;
                if (i_reg == IW'(CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign bearing = wfc_pkg::ERR_W'(zr >>> 14);

endmodule

@@ sv/waypoint_follow_controller_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_follow_controller_top
// Turn-then-drive waypoint follower with a shared multiplier and CORDIC.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries requests: tuser = opcode (pose step or table write), tdata
//   holds entry_index, pos_x, pos_y, heading. A table write stores one
//   waypoint; a pose step yields a turn or drive command, or none if stopped.
//   m_* carries one result per request: turn_rate, drive_speed,
//   reached_now, target_slot, cycle_done.
//   cfg_we / cfg_index / cfg_data write the registers; write only when idle.
// Sequence:
//   a pose request passes the table read, the multiplier passes (three
//   squares, one gain product) and the CORDIC iterations before its result;
//   a pose step that is stopped after a full cycle in closed loop skips the
//   CORDIC and the gain product, and a table write goes straight to the
//   result. s_tready is high only in the idle state, so a new request is
//   taken only after the previous result is loaded into the output register.
// Reset clears target index, pass counter, cycle flag and the registers to
//   their defaults; the waypoint table is not cleared and must be written.
// A stalled result is held in the output register; the next request may
//   be accepted meanwhile and waits in its final state for the output.
// ----------------------------------------------------------------------------
module waypoint_follow_controller_top #(
    parameter int MAX_WAYPOINTS = wfc_pkg::MAX_WAYPOINTS_DEF,
    parameter int CORDIC_STEPS  = wfc_pkg::CORDIC_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,  // entry_index, pos_x, pos_y, heading, pad
    input  logic [0:0]  s_tuser,  // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,  // turn_rate, drive_speed, reached_now,
                                  // target_slot, cycle_done, pad
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [30:0] cfg_data
);

    localparam int TW = $clog2(MAX_WAYPOINTS);
    localparam int CW = $clog2(MAX_WAYPOINTS + 2);

    typedef enum logic [3:0] {
        ST_IDLE, ST_RDA, ST_SQX, ST_SQY, ST_SQT, ST_CMP, ST_RDB,
        ST_CST, ST_CRUN, ST_WRAP, ST_GMUL, ST_FIN
    } state_t;

    state_t             state_reg;
    logic [4:0]         num_wp_reg;
    logic [17:0]        head_tol_reg;
    logic [30:0]        pos_tol_reg;
    logic [30:0]        rot_speed_reg;
    logic [30:0]        fwd_speed_reg;
    logic [30:0]        gain_reg;
    logic               closed_reg;

    logic [TW-1:0]      tgt_reg;
    logic [CW-1:0]      rc_reg;
    logic               flag_reg;
    logic               reached_reg;
    logic               is_write_reg;
    logic               skip_reg;
    logic signed [31:0] px_reg;
    logic signed [31:0] py_reg;
    logic signed [18:0] hd_reg;
    logic [64:0]        acc_reg;
    logic signed [wfc_pkg::ERR_W-1:0] err_reg;
    logic               out_valid_reg;
    logic [71:0]        out_data_reg;

    logic               accept;
    logic [3:0]         in_slot;
    logic [CW-1:0]      n_act;
    logic [CW-1:0]      cap;
    logic [TW-1:0]      tgt_fix;
    logic [63:0]        rd_data;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [31:0]        ax;
    logic [31:0]        ay;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        prod;
    logic               slot_ok;
    logic               cordic_start;
    logic               cordic_done;
    logic signed [wfc_pkg::ERR_W-1:0] bearing;
    logic signed [wfc_pkg::ERR_W-1:0] err_raw;
    logic [31:0]        err_abs;
    logic signed [51:0] gain_signed;
    logic signed [35:0] prop;
    logic signed [35:0] lim;
    logic signed [31:0] turn_val;
    logic [30:0]        drive_val;
    logic [CW-1:0]      rc_inc;

    assign accept  = s_tvalid && s_tready;
    assign in_slot = s_tdata[3:0];
    assign slot_ok = (32'(in_slot) < 32'(MAX_WAYPOINTS));

    // active waypoint count, clamped to 1..MAX_WAYPOINTS
    always_comb
    begin
        if (num_wp_reg == 5'd0)
        begin
            n_act = CW'(1);
        end
        else if (32'(num_wp_reg) > 32'(MAX_WAYPOINTS))
        begin
            n_act = CW'(MAX_WAYPOINTS);
        end
        else
        begin
            n_act = CW'(num_wp_reg);
        end
    end

    assign cap     = n_act + 1'b1;
    assign tgt_fix = (CW'(tgt_reg) >= n_act) ? '0 : tgt_reg;
    assign rc_inc  = (rc_reg >= cap) ? cap : rc_reg + 1'b1;

    wfc_ram #(
        .WIDTH (64),
        .DEPTH (MAX_WAYPOINTS)
    ) u_table (
        .clk   (clk),
        .we    (accept && s_tuser[0] == wfc_pkg::OP_WRITE && slot_ok),
        .waddr (TW'(in_slot)),
        .wdata (s_tdata[67:4]),
        .raddr (tgt_reg),
        .rdata (rd_data)
    );

    assign dx = $signed({rd_data[31], rd_data[31:0]}) - $signed({px_reg[31], px_reg});
    assign dy = $signed({rd_data[63], rd_data[63:32]}) - $signed({py_reg[31], py_reg});
    assign ax = 32'(dx < 0 ? -dx : dx);
    assign ay = 32'(dy < 0 ? -dy : dy);
    assign err_abs = 32'(err_reg < 0 ? -err_reg : err_reg);

    always_comb
    begin
        case (state_reg)
            ST_SQX:
            begin
                mul_a = ax;
                mul_b = ax;
            end
            ST_SQY:
            begin
                mul_a = ay;
                mul_b = ay;
            end
            ST_SQT:
            begin
                mul_a = {1'b0, pos_tol_reg};
                mul_b = {1'b0, pos_tol_reg};
            end
            default:
            begin
                mul_a = {1'b0, gain_reg};
                mul_b = err_abs;
            end
        endcase
    end

    wfc_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    assign cordic_start = (state_reg == ST_CST) && !(closed_reg && flag_reg);

    wfc_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .dx      (dx),
        .dy      (dy),
        .done    (cordic_done),
        .bearing (bearing)
    );

    assign err_raw = bearing - wfc_pkg::ERR_W'(hd_reg);

    // proportional turn, rounded, then clamped to the rotation speed
    assign gain_signed = (err_reg < 0) ? -$signed({1'b0, prod[50:0]})
                                       : $signed({1'b0, prod[50:0]});
    assign prop = 36'((gain_signed + 52'sd32768) >>> 16);
    assign lim  = $signed({5'd0, rot_speed_reg});

    always_comb
    begin
        turn_val  = '0;
        drive_val = '0;
        if (!is_write_reg && !skip_reg)
        begin
            if ($signed({1'b0, err_abs}) < $signed(33'({head_tol_reg})))
            begin
                drive_val = fwd_speed_reg;
            end
            else if (!closed_reg)
            begin
                turn_val = (err_reg > 0) ? $signed({1'b0, rot_speed_reg})
                                         : -$signed({1'b0, rot_speed_reg});
            end
            else if (prop > lim)
            begin
                turn_val = 32'(lim);
            end
            else if (prop < -lim)
            begin
                turn_val = 32'(-lim);
            end
            else
            begin
                turn_val = 32'(prop);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_wp_reg    <= wfc_pkg::RST_NUM_WAYPOINTS;
            head_tol_reg  <= wfc_pkg::RST_HEADING_TOL;
            pos_tol_reg   <= wfc_pkg::RST_POSITION_TOL;
            rot_speed_reg <= '0;
            fwd_speed_reg <= '0;
            gain_reg      <= '0;
            closed_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wfc_pkg::REG_NUM_WAYPOINTS:  num_wp_reg    <= cfg_data[4:0];
                wfc_pkg::REG_HEADING_TOL:    head_tol_reg  <= cfg_data[17:0];
                wfc_pkg::REG_POSITION_TOL:   pos_tol_reg   <= cfg_data;
                wfc_pkg::REG_ROTATION_SPEED: rot_speed_reg <= cfg_data;
                wfc_pkg::REG_FORWARD_SPEED:  fwd_speed_reg <= cfg_data;
                wfc_pkg::REG_TURN_GAIN:      gain_reg      <= cfg_data;
                wfc_pkg::REG_CLOSED_LOOP:    closed_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tgt_reg       <= '0;
            rc_reg        <= '0;
            flag_reg      <= 1'b0;
            reached_reg   <= 1'b0;
            is_write_reg  <= 1'b0;
            skip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // the final state reloads the output itself when it drains
            if (out_valid_reg && m_tready && state_reg != ST_FIN)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        reached_reg <= 1'b0;
                        skip_reg    <= 1'b0;
                        if (s_tuser[0] == wfc_pkg::OP_WRITE)
                        begin
                            is_write_reg <= 1'b1;
                            state_reg    <= ST_FIN;
                        end
                        else
                        begin
                            is_write_reg <= 1'b0;
                            tgt_reg      <= tgt_fix;
                            px_reg       <= s_tdata[35:4];
                            py_reg       <= s_tdata[67:36];
                            hd_reg       <= s_tdata[86:68];
                            state_reg    <= ST_RDA;
                        end
                    end
                end
                ST_RDA:  state_reg <= ST_SQX;
                ST_SQX:  state_reg <= ST_SQY;
                ST_SQY:
                begin
                    acc_reg   <= {1'b0, prod};
                    state_reg <= ST_SQT;
                end
                ST_SQT:
                begin
                    acc_reg   <= acc_reg + 65'(prod);
                    state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    // prod now holds the squared tolerance
                    if (acc_reg < 65'(prod))
                    begin
                        reached_reg <= 1'b1;
                        tgt_reg     <= (CW'(tgt_reg) + 1'b1 >= n_act) ? '0
                                                                    : tgt_reg + 1'b1;
                        rc_reg      <= rc_inc;
                        if (rc_inc == cap)
                        begin
                            flag_reg <= 1'b1;
                        end
                    end
                    state_reg <= ST_RDB;
                end
                ST_RDB:  state_reg <= ST_CST;
                ST_CST:
                begin
                    if (closed_reg && flag_reg)
                    begin
                        skip_reg  <= 1'b1;
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        state_reg <= ST_CRUN;
                    end
                end
                ST_CRUN:
                begin
                    if (cordic_done)
                    begin
                        state_reg <= ST_WRAP;
                    end
                end
                ST_WRAP:
                begin
                    if (err_raw > wfc_pkg::PI_Q16)
                    begin
                        err_reg <= err_raw - wfc_pkg::TWO_PI_Q16;
                    end
                    else if (err_raw < -wfc_pkg::PI_Q16)
                    begin
                        err_reg <= err_raw + wfc_pkg::TWO_PI_Q16;
                    end
                    else
                    begin
                        err_reg <= err_raw;
                    end
                    state_reg <= ST_GMUL;
                end
                ST_GMUL: state_reg <= ST_FIN;
                ST_FIN:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {3'd0, flag_reg, 4'(tgt_reg), reached_reg,
                                          drive_val, turn_val};
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_tgt_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(tgt_reg) < 32'(MAX_WAYPOINTS))
        else $error("target index beyond table");

    a_rc_cap: assert property (@(posedge clk) disable iff (!rst_n)
        32'(rc_reg) <= 32'(MAX_WAYPOINTS + 1))
        else $error("pass counter beyond cap");

    a_flag_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        flag_reg |=> flag_reg)
        else $error("cycle flag cleared");

    a_cordic_done: assert property (@(posedge clk) disable iff (!rst_n)
        cordic_done |-> state_reg == ST_CRUN)
        else $error("cordic finished outside its wait state");

endmodule

@@ test/tb_waypoint_follow_controller_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_waypoint_follow_controller_top
// Self-checking bench for the waypoint follower. Table writes and pose
// requests go in on the request stream while a local predictor tracks the
// target slot, the pass counter and the cycle flag. Each predicted command
// is compared field by field with what comes out of the result stream.
// Both streams stall in random bursts, except in the last, quiet phase. The
// registers are changed between phases, once the block is idle.
// ----------------------------------------------------------------------------
module tb_waypoint_follow_controller_top;

    localparam int  SLOTS     = 16;
    localparam int  LIMIT     = 800000;
    localparam longint PI_V   = 205887;
    localparam longint TPI_V  = 411775;
    localparam longint PI_Z   = 64'sd3373259426;

    typedef struct packed {
        logic        op;
        logic [3:0]  slot;
        logic [31:0] px;
        logic [31:0] py;
        logic [18:0] hd;
    } pose_req_t;

    typedef struct packed {
        logic [31:0] turn;
        logic [30:0] drive;
        logic        reached;
        logic [3:0]  slot;
        logic        done;
    } command_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;   // entry_index, pos_x, pos_y, heading, pad
    logic [0:0]  s_tuser;   // opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // turn_rate, drive_speed, reached_now,
                            // target_slot, cycle_done, pad
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [30:0] cfg_data;

    waypoint_follow_controller_top u_top (.*);

    // atan(2^-i), Q2.30
    longint atan_tab [16] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF
    };

    // predictor state
    longint      wp_x [SLOTS];
    longint      wp_y [SLOTS];
    int unsigned tgt;
    int unsigned pass_cnt;
    bit          cyc_flag;
    int unsigned n_wp;
    longint      head_tol, pos_tol, rot_spd, fwd_spd, gain;
    bit          closed;

    pose_req_t pending_q [$];
    command_t  cmd_q [$];

    int  errors;
    int  n_checked;
    int  n_reached;
    int  n_turns;
    int  cycles;
    bit  quiet;
    bit  s_fire;
    int  s_gap;
    int  m_gap;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic int unsigned active_n();
        int unsigned n;
        n = n_wp;
        if (n == 0)
            n = 1;
        if (n > SLOTS)
            n = SLOTS;
        return n;
    endfunction

    function automatic longint unsigned range_sq(longint dx, longint dy);
        longint unsigned ax, ay, a, b, s;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        a  = ax * ax;
        b  = ay * ay;
        s  = a + b;
        return (s < a) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
    endfunction

    function automatic longint bearing(longint dx, longint dy);
        longint x, y, z, xs, ys;
        z = 0;
        if (dx == 0 && dy == 0)
            return 0;
        x = dx * 16777216;
        y = dy * 16777216;
        if (x < 0)
        begin
            z = (y >= 0) ? PI_Z : -PI_Z;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 16; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_tab[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_tab[i];
            end
        end
        return (z + 8192) >>> 14;
    endfunction

    // advances the predictor by one request and returns the command
    function automatic command_t follow_step(pose_req_t r);
        command_t    c;
        longint      px, py, hd, err, dx, dy, t;
        int unsigned n;
        c = '0;
        if (r.op == wfc_pkg::OP_WRITE)
        begin
            wp_x[r.slot] = longint'($signed(r.px));
            wp_y[r.slot] = longint'($signed(r.py));
        end
        else
        begin
            n = active_n();
            if (tgt >= n)
                tgt = 0;
            px = longint'($signed(r.px));
            py = longint'($signed(r.py));
            hd = longint'($signed(r.hd));
            if (range_sq(wp_x[tgt] - px, wp_y[tgt] - py) <
                longint'(pos_tol * pos_tol))
            begin
                c.reached = 1'b1;
                tgt++;
                if (tgt >= n)
                    tgt = 0;
                pass_cnt = (pass_cnt >= n + 1) ? n + 1 : pass_cnt + 1;
                if (pass_cnt == n + 1)
                    cyc_flag = 1'b1;
            end
            if (!(closed && cyc_flag))
            begin
                dx  = wp_x[tgt] - px;
                dy  = wp_y[tgt] - py;
                err = bearing(dx, dy) - hd;
                while (err > PI_V)
                    err -= TPI_V;
                while (err < -PI_V)
                    err += TPI_V;
                if (((err < 0) ? -err : err) < head_tol)
                    c.drive = fwd_spd[30:0];
                else if (!closed)
                    c.turn = (err > 0) ? rot_spd[31:0] : 32'(-rot_spd);
                else
                begin
                    t = (gain * err + 32768) >>> 16;
                    if (t > rot_spd)
                        t = rot_spd;
                    if (t < -rot_spd)
                        t = -rot_spd;
                    c.turn = t[31:0];
                end
            end
        end
        c.slot = tgt[3:0];
        c.done = cyc_flag;
        return c;
    endfunction

    function automatic void queue_req(pose_req_t r);
        pending_q.push_back(r);
        cmd_q.push_back(follow_step(r));
    endfunction

    function automatic logic [31:0] near_coord();
        if ($urandom_range(0, 7) == 0)
            return $urandom();
        return 32'($signed($urandom_range(0, 2097152)) - 1048576);
    endfunction

    function automatic logic [18:0] rand_heading();
        if ($urandom_range(0, 5) == 0)
            return 19'($urandom());
        return 19'(longint'($urandom_range(0, 411774)) - PI_V);
    endfunction

    task automatic write_reg(logic [2:0] idx, longint val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[30:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            wfc_pkg::REG_NUM_WAYPOINTS:  n_wp     = val[4:0];
            wfc_pkg::REG_HEADING_TOL:    head_tol = val[17:0];
            wfc_pkg::REG_POSITION_TOL:   pos_tol  = val[30:0];
            wfc_pkg::REG_ROTATION_SPEED: rot_spd  = val[30:0];
            wfc_pkg::REG_FORWARD_SPEED:  fwd_spd  = val[30:0];
            wfc_pkg::REG_TURN_GAIN:      gain     = val[30:0];
            default:                     closed   = val[0];
        endcase
        @(negedge clk);
    endtask

    task automatic wait_idle();
        wait (pending_q.size() == 0 && cmd_q.size() == 0);
        repeat (40) @(negedge clk);
    endtask

    task automatic run_phase(int count);
        pose_req_t   r;
        int unsigned t;
        longint      span, ox, oy;
        for (int k = 0; k < count; k++)
        begin
            r = '0;
            if ($urandom_range(0, 11) == 0)
            begin
                r.op   = wfc_pkg::OP_WRITE;
                r.slot = 4'($urandom());
                r.px   = near_coord();
                r.py   = near_coord();
                r.hd   = 19'($urandom());
            end
            else
            begin
                r.op   = wfc_pkg::OP_POSE;
                r.slot = 4'($urandom());
                r.hd   = rand_heading();
                t = (tgt >= active_n()) ? 0 : tgt;
                if ($urandom_range(0, 9) < 7)
                begin
                    // aim close to the current target so that it can be reached
                    span = ($urandom_range(0, 1) ? pos_tol : pos_tol / 2) + 1;
                    if (span > 64'h4000_0000)
                        span = 64'h4000_0000;
                    ox = longint'($urandom_range(0, 32'(2 * span))) - span;
                    oy = longint'($urandom_range(0, 32'(2 * span))) - span;
                    r.px = 32'(wp_x[t] + ox);
                    r.py = 32'(wp_y[t] + oy);
                end
                else
                begin
                    r.px = $urandom();
                    r.py = $urandom();
                end
            end
            queue_req(r);
        end
    endtask

    // request driver
    always @(posedge clk)
        s_fire <= s_tvalid & s_tready;

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            s_gap    <= 0;
        end
        else if (s_tvalid && !s_fire)
            s_tvalid <= 1'b1;
        else if (s_gap > 0)
        begin
            s_gap    <= s_gap - 1;
            s_tvalid <= 1'b0;
        end
        else if (pending_q.size() > 0)
        begin
            pose_req_t r;
            r = pending_q.pop_front();
            s_tvalid <= 1'b1;
            s_tuser  <= r.op;
            s_tdata  <= {1'b0, r.hd, r.py, r.px, r.slot};
            if (!quiet && $urandom_range(0, 5) == 0)
                s_gap <= $urandom_range(1, 17);
        end
        else
            s_tvalid <= 1'b0;
    end

    // result side stalls
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            m_gap    <= 0;
        end
        else if (m_gap > 0)
        begin
            m_gap    <= m_gap - 1;
            m_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            m_gap    <= $urandom_range(0, 16);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // result checker
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout at %0t", $time);
            $display("simulation failed");
            $finish;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            command_t got, want;
            got = {m_tdata[31:0], m_tdata[62:32], m_tdata[63], m_tdata[67:64],
                   m_tdata[68]};
            if (cmd_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors <= errors + 1;
            end
            else
            begin
                want = cmd_q.pop_front();
                n_checked <= n_checked + 1;
                if (want.reached)
                    n_reached <= n_reached + 1;
                if (want.turn != 0)
                    n_turns <= n_turns + 1;
                if (got.turn !== want.turn || got.drive !== want.drive ||
                    got.reached !== want.reached || got.slot !== want.slot ||
                    got.done !== want.done)
                begin
                    $display("%0t: expected turn %h drive %h reach %b slot %0d done %b",
                             $time, want.turn, want.drive, want.reached, want.slot,
                             want.done);
                    $display("%0t:   actual turn %h drive %h reach %b slot %0d done %b",
                             $time, got.turn, got.drive, got.reached, got.slot,
                             got.done);
                    errors <= errors + 1;
                end
            end
        end
    end

    initial
    begin
        pose_req_t r;
        errors    = 0;
        n_checked = 0;
        n_reached = 0;
        n_turns   = 0;
        cycles    = 0;
        quiet     = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        tgt       = 0;
        pass_cnt  = 0;
        cyc_flag  = 1'b0;
        n_wp      = wfc_pkg::RST_NUM_WAYPOINTS;
        head_tol  = wfc_pkg::RST_HEADING_TOL;
        pos_tol   = wfc_pkg::RST_POSITION_TOL;
        rot_spd   = 0;
        fwd_spd   = 0;
        gain      = 0;
        closed    = 1'b0;
        foreach (wp_x[i])
        begin
            wp_x[i] = 0;
            wp_y[i] = 0;
        end
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // fill the whole table first, extremes in the outer slots
        for (int i = 0; i < SLOTS; i++)
        begin
            r = '0;
            r.op   = wfc_pkg::OP_WRITE;
            r.slot = i[3:0];
            r.px   = (i == 0) ? 32'h0 : (i == 15) ? 32'h7FFF_FFFF : near_coord();
            r.py   = (i == 15) ? 32'h8000_0000 : near_coord();
            r.hd   = 19'h7FFFF;
            queue_req(r);
        end
        // pose at the origin, then extreme poses and headings
        r = '0;
        r.op = wfc_pkg::OP_POSE;
        queue_req(r);
        r.hd = 19'(PI_V);
        queue_req(r);
        r.hd = 19'(-PI_V);
        r.px = 32'h8000_0000;
        r.py = 32'h7FFF_FFFF;
        queue_req(r);
        r.hd = 19'h3FFFF;
        r.px = 32'h7FFF_FFFF;
        r.py = 32'h8000_0000;
        queue_req(r);
        r.hd = 19'h40000;
        r.px = 32'hFFFF_FFFF;
        queue_req(r);
        wait_idle();

        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(wfc_pkg::REG_NUM_WAYPOINTS, 4);
                    write_reg(wfc_pkg::REG_HEADING_TOL, 1311);
                    write_reg(wfc_pkg::REG_POSITION_TOL, 40000);
                    write_reg(wfc_pkg::REG_ROTATION_SPEED, 65536);
                    write_reg(wfc_pkg::REG_FORWARD_SPEED, 32768);
                    write_reg(wfc_pkg::REG_TURN_GAIN, 131072);
                    write_reg(wfc_pkg::REG_CLOSED_LOOP, 0);
                end
                1:
                begin
                    write_reg(wfc_pkg::REG_NUM_WAYPOINTS, 16);
                    write_reg(wfc_pkg::REG_HEADING_TOL, 0);
                    write_reg(wfc_pkg::REG_POSITION_TOL, 0);
                    write_reg(wfc_pkg::REG_ROTATION_SPEED, 32'h7FFF_FFFF);
                    write_reg(wfc_pkg::REG_FORWARD_SPEED, 32'h7FFF_FFFF);
                    write_reg(wfc_pkg::REG_TURN_GAIN, 32'h7FFF_FFFF);
                    write_reg(wfc_pkg::REG_CLOSED_LOOP, 1);
                end
                2:
                begin
                    write_reg(wfc_pkg::REG_NUM_WAYPOINTS, 2);
                    write_reg(wfc_pkg::REG_HEADING_TOL, 205887);
                    write_reg(wfc_pkg::REG_POSITION_TOL, 200000);
                    write_reg(wfc_pkg::REG_ROTATION_SPEED, 100000);
                    write_reg(wfc_pkg::REG_CLOSED_LOOP, 1);
                end
                3:
                begin
                    // zero count behaves as one; the next phase sets an oversized count
                    write_reg(wfc_pkg::REG_NUM_WAYPOINTS, ph == 3 ? 0 : 31);
                    write_reg(wfc_pkg::REG_HEADING_TOL, 18'h3FFFF);
                    write_reg(wfc_pkg::REG_POSITION_TOL, 32'h7FFF_FFFF);
                    write_reg(wfc_pkg::REG_CLOSED_LOOP, 0);
                end
                4:
                begin
                    write_reg(wfc_pkg::REG_NUM_WAYPOINTS, 31);
                    write_reg(wfc_pkg::REG_HEADING_TOL, 5000);
                    write_reg(wfc_pkg::REG_POSITION_TOL, 60000);
                    write_reg(wfc_pkg::REG_TURN_GAIN, 0);
                    write_reg(wfc_pkg::REG_CLOSED_LOOP, 1);
                end
                default:
                begin
                    write_reg(wfc_pkg::REG_NUM_WAYPOINTS, $urandom_range(1, 17));
                    write_reg(wfc_pkg::REG_HEADING_TOL, $urandom_range(0, 205887));
                    write_reg(wfc_pkg::REG_POSITION_TOL, $urandom_range(1000, 300000));
                    write_reg(wfc_pkg::REG_ROTATION_SPEED, $urandom() >> 1);
                    write_reg(wfc_pkg::REG_FORWARD_SPEED, $urandom() >> 1);
                    write_reg(wfc_pkg::REG_TURN_GAIN, $urandom_range(0, 1 << 22));
                    write_reg(wfc_pkg::REG_CLOSED_LOOP, $urandom_range(0, 1));
                end
            endcase
            if (ph == 8)
                quiet = 1'b1;
            run_phase(170);
            wait_idle();
        end

        $display("checked %0d commands, %0d waypoint reaches, %0d turn commands",
                 n_checked, n_reached, n_turns);
        $display("nine register settings, open and closed loop, both streams stalled");
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ files.f @@
sv/wfc_pkg.sv
sv/wfc_ram.sv
sv/wfc_mul.sv
sv/wfc_cordic.sv
sv/waypoint_follow_controller_top.sv
test/tb_waypoint_follow_controller_top.sv
